// ----- rtl/core/load_cell_tare_average_iir_unit_defines.svh -----
// Assertion macros for the load cell tare and filter block
`ifndef LOAD_CELL_TARE_AVERAGE_IIR_UNIT_DEFINES_SVH
`define LOAD_CELL_TARE_AVERAGE_IIR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LCTAI_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lctai assertion failed");
`define LCTAI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lctai assertion failed");
`else
`define LCTAI_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define LCTAI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/lctai_pkg.sv -----
// Types, constants and helpers shared by the load cell tare and filter block
`default_nettype none
package lctai_pkg;

   localparam int TARE_SAMPLES_RAW = 10;
   localparam int AVG_SAMPLES_RAW  = 5;
   localparam int TARE_SAMPLES = (TARE_SAMPLES_RAW < 1) ? 1 :
                                 ((TARE_SAMPLES_RAW > 15) ? 15 : TARE_SAMPLES_RAW);
   localparam int AVG_SAMPLES  = (AVG_SAMPLES_RAW < 1) ? 1 :
                                 ((AVG_SAMPLES_RAW > 15) ? 15 : AVG_SAMPLES_RAW);

   localparam int RAW_W    = 24;
   localparam int SUM_W    = 29;
   localparam int MAG_W    = 28;
   localparam int CNT_W    = 4;
   localparam int DIFF_W   = 25;
   localparam int WEIGHT_W = 32;
   localparam int GPC_W    = 32;
   localparam int ALPHA_W  = 17;
   localparam int MC_W     = 33;
   localparam int MQ_W     = 32;
   localparam int ACC_W    = 35;
   localparam int PROD_W   = ACC_W + MQ_W;
   localparam int SHR_W    = PROD_W - 16;
   localparam int WIDE_W   = 52;
   localparam int STEP_W   = 5;

   localparam int DIV_STEPS = MAG_W;
   localparam int MUL_STEPS = MQ_W;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [GPC_W-1:0]   GPC_RESET    = 32'd39017;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 17'd39322;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 17'h10000;
   localparam logic [RAW_W-1:0]   TARE_RESET   = 24'd254700;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX  = 32'h7FFF_FFFF;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MIN  = 32'h8000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRAMS_PER_COUNT = 1'b0,
      CSR_ALPHA           = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_MEAN,
      S_SCALE,
      S_SCALE_END,
      S_IIR,
      S_IIR_END,
      S_DONE
   } state_type;

   function automatic logic [CNT_W-1:0] group_need(input logic kind);
      return kind ? CNT_W'(TARE_SAMPLES) : CNT_W'(AVG_SAMPLES);
   endfunction

   function automatic logic [WEIGHT_W-1:0] sat32(input logic [WIDE_W-1:0] v);
      logic [WIDE_W-WEIGHT_W:0] top;
      top = v[WIDE_W-1:WEIGHT_W-1];
      if (top == '0 || top == '1) begin
         return v[WEIGHT_W-1:0];
      end
      return v[WIDE_W-1] ? WEIGHT_MIN : WEIGHT_MAX;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/lctai_req_if.sv -----
// Input channel: raw converter code and sample kind
`default_nettype none
interface lctai_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] raw_code;
   logic        kind;

   modport source (output valid, output raw_code, output kind, input ready);
   modport sink   (input valid, input raw_code, input kind, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lctai_rsp_if.sv -----
// Result channel: filtered weight and tare completion flag
`default_nettype none
interface lctai_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] weight_g_q8;
   logic               tare_done;

   modport source (output valid, output weight_g_q8, output tare_done, input ready);
   modport sink   (input valid, input weight_g_q8, input tare_done, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/load_cell_tare_average_iir_unit.sv -----
// Load cell tare averaging, scaling and first-order IIR filter, bit-serial datapath
//
// req carries one converter word (24-bit two's complement code and a kind bit:
// 0 weight, 1 tare); rsp carries the filtered weight in grams (signed Q24.8)
// and a tare-done flag. csr_we/csr_index/csr_wdata write the scale (index 0)
// and alpha (index 1) registers; the user must write them only while the block
// is idle, which the block itself does not enforce. A word that does not close
// its group is added to the running sum. A word that closes a group runs a
// bit-serial divide by the group size: a tare group then stores the mean as
// the new baseline and reports tare done. A weight group then runs the shared
// shift-add multiplier for the scale and, once seeded, again for the filter.
// The divider and multiplier handle one bit a cycle; req is not ready while
// they work.
// A finished result sits in the output register until taken; req keeps
// accepting words meanwhile. If the next group completes before rsp drains,
// the block holds that result and stalls req until the register frees.
// Reset (synchronous) empties the group, sets the baseline to 254700 counts,
// unseeds the filter and restores the register defaults.
`default_nettype none
`include "load_cell_tare_average_iir_unit_defines.svh"
module load_cell_tare_average_iir_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   lctai_req_if.sink                               req,
   lctai_rsp_if.source                             rsp,
   input  wire logic                               csr_we,
   input  wire logic [lctai_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lctai_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SUM_W  = lctai_pkg::SUM_W;
   localparam int MAG_W  = lctai_pkg::MAG_W;
   localparam int CNT_W  = lctai_pkg::CNT_W;
   localparam int RAW_W  = lctai_pkg::RAW_W;
   localparam int DIFF_W = lctai_pkg::DIFF_W;
   localparam int W_W    = lctai_pkg::WEIGHT_W;
   localparam int MC_W   = lctai_pkg::MC_W;
   localparam int MQ_W   = lctai_pkg::MQ_W;
   localparam int ACC_W  = lctai_pkg::ACC_W;
   localparam int PROD_W = lctai_pkg::PROD_W;
   localparam int SHR_W  = lctai_pkg::SHR_W;
   localparam int WIDE_W = lctai_pkg::WIDE_W;
   localparam int STEP_W = lctai_pkg::STEP_W;
   localparam int A_W    = lctai_pkg::ALPHA_W;

   lctai_pkg::state_type state_ff, state_in;

   logic [lctai_pkg::GPC_W-1:0] gpc_ff;
   logic [A_W-1:0]              alpha_ff;

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              group_kind_ff, group_kind_in;
   logic [RAW_W-1:0]  tare_ff, tare_in;
   logic [W_W-1:0]    fw_ff, fw_in;
   logic              seeded_ff, seeded_in;

   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  need_ff, need_in;
   logic [MAG_W-1:0]  quot_ff, quot_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [MC_W-1:0]   mcand_ff, mcand_in;
   logic [MQ_W-1:0]   mq_ff, mq_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;

   logic [W_W-1:0]    res_weight_ff, res_weight_in;
   logic              res_tare_ff, res_tare_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [W_W-1:0]    rsp_weight_ff, rsp_weight_in;
   logic              rsp_tare_ff, rsp_tare_in;

   logic              accept;
   logic              out_free;
   logic [SUM_W-1:0]  sample;
   logic [SUM_W-1:0]  base_sum, acc_sum, neg_sum;
   logic [CNT_W-1:0]  base_cnt, acc_cnt, need_req;
   logic [CNT_W:0]    trial, trial_sub;
   logic              ge;
   logic [SUM_W-1:0]  mean_full;
   logic [DIFF_W-1:0] diff;
   logic [ACC_W-1:0]  addend, mul_sum;
   logic [PROD_W-1:0] prod;
   logic [SHR_W-1:0]  shr;
   logic [W_W-1:0]    grams;
   logic [MC_W-1:0]   g_minus_fw;
   logic [WIDE_W-1:0] iir_sum;
   logic [A_W-1:0]    alpha_eff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gpc_ff   <= lctai_pkg::GPC_RESET;
         alpha_ff <= lctai_pkg::ALPHA_RESET;
      end else if (csr_we) begin
         unique case (lctai_pkg::csr_reg_type'(csr_index))
            lctai_pkg::CSR_GRAMS_PER_COUNT: gpc_ff   <= csr_wdata[lctai_pkg::GPC_W-1:0];
            lctai_pkg::CSR_ALPHA:           alpha_ff <= csr_wdata[A_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lctai_pkg::S_IDLE;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         group_kind_ff <= 1'b0;
         tare_ff       <= lctai_pkg::TARE_RESET;
         fw_ff         <= '0;
         seeded_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sum_ff        <= sum_in;
         cnt_ff        <= cnt_in;
         group_kind_ff <= group_kind_in;
         tare_ff       <= tare_in;
         fw_ff         <= fw_in;
         seeded_ff     <= seeded_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff        <= neg_in;
      need_ff       <= need_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      mcand_ff      <= mcand_in;
      mq_ff         <= mq_in;
      acc_ff        <= acc_in;
      res_weight_ff <= res_weight_in;
      res_tare_ff   <= res_tare_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_tare_ff   <= rsp_tare_in;
   end

   // datapath terms
   always_comb begin
      sample    = {{(SUM_W-RAW_W){req.raw_code[RAW_W-1]}}, req.raw_code};
      base_sum  = (req.kind != group_kind_ff) ? '0 : sum_ff;
      base_cnt  = (req.kind != group_kind_ff) ? '0 : cnt_ff;
      acc_sum   = base_sum + sample;
      acc_cnt   = base_cnt + CNT_W'(1);
      neg_sum   = '0 - acc_sum;
      need_req  = lctai_pkg::group_need(req.kind);

      trial     = {rem_ff, quot_ff[MAG_W-1]};
      ge        = (trial >= {1'b0, need_ff});
      trial_sub = trial - {1'b0, need_ff};

      mean_full = neg_ff ? ('0 - {1'b0, quot_ff}) : {1'b0, quot_ff};
      diff      = {mean_full[RAW_W-1], mean_full[RAW_W-1:0]}
                  - {tare_ff[RAW_W-1], tare_ff};

      addend    = mq_ff[0] ? {{(ACC_W-MC_W){mcand_ff[MC_W-1]}}, mcand_ff} : '0;
      mul_sum   = acc_ff + addend;

      prod      = {acc_ff, mq_ff};
      shr       = prod[PROD_W-1:16];
      grams     = lctai_pkg::sat32({{(WIDE_W-SHR_W){shr[SHR_W-1]}}, shr});
      g_minus_fw = {grams[W_W-1], grams} - {fw_ff[W_W-1], fw_ff};
      iir_sum   = {{(WIDE_W-SHR_W){shr[SHR_W-1]}}, shr}
                  + {{(WIDE_W-W_W){fw_ff[W_W-1]}}, fw_ff};
      alpha_eff = (alpha_ff[A_W-1] && (alpha_ff[A_W-2:0] != '0))
                  ? lctai_pkg::ALPHA_ONE : alpha_ff;
   end

   assign accept   = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      group_kind_in = group_kind_ff;
      tare_in       = tare_ff;
      fw_in         = fw_ff;
      seeded_in     = seeded_ff;
      neg_in        = neg_ff;
      need_in       = need_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      mcand_in      = mcand_ff;
      mq_in         = mq_ff;
      acc_in        = acc_ff;
      res_weight_in = res_weight_ff;
      res_tare_in   = res_tare_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_tare_in   = rsp_tare_ff;
      rsp_valid_in  = rsp.ready ? 1'b0 : rsp_valid_ff;
      req.ready     = (state_ff == lctai_pkg::S_IDLE);

      unique case (state_ff)
         lctai_pkg::S_IDLE: begin
            if (accept) begin
               group_kind_in = req.kind;
               if (acc_cnt == need_req) begin
                  sum_in   = '0;
                  cnt_in   = '0;
                  need_in  = need_req;
                  neg_in   = acc_sum[SUM_W-1];
                  quot_in  = acc_sum[SUM_W-1] ? neg_sum[MAG_W-1:0] : acc_sum[MAG_W-1:0];
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = lctai_pkg::S_DIV;
               end else begin
                  sum_in = acc_sum;
                  cnt_in = acc_cnt;
               end
            end
         end
         lctai_pkg::S_DIV: begin
            // restoring divide, one quotient bit a cycle
            rem_in  = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            quot_in = {quot_ff[MAG_W-2:0], ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(lctai_pkg::DIV_STEPS - 1)) begin
               state_in = lctai_pkg::S_MEAN;
            end
         end
         lctai_pkg::S_MEAN: begin
            if (group_kind_ff) begin
               tare_in       = mean_full[RAW_W-1:0];
               seeded_in     = 1'b0;
               res_weight_in = '0;
               res_tare_in   = 1'b1;
               state_in      = lctai_pkg::S_DONE;
            end else begin
               mcand_in = {{(MC_W-DIFF_W){diff[DIFF_W-1]}}, diff};
               mq_in    = gpc_ff;
               acc_in   = '0;
               step_in  = '0;
               state_in = lctai_pkg::S_SCALE;
            end
         end
         lctai_pkg::S_SCALE, lctai_pkg::S_IIR: begin
            // shift-add multiply, one multiplier bit a cycle
            acc_in  = {mul_sum[ACC_W-1], mul_sum[ACC_W-1:1]};
            mq_in   = {mul_sum[0], mq_ff[MQ_W-1:1]};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(lctai_pkg::MUL_STEPS - 1)) begin
               state_in = (state_ff == lctai_pkg::S_SCALE) ? lctai_pkg::S_SCALE_END
                                                           : lctai_pkg::S_IIR_END;
            end
         end
         lctai_pkg::S_SCALE_END: begin
            if (!seeded_ff) begin
               fw_in         = grams;
               seeded_in     = 1'b1;
               res_weight_in = grams;
               res_tare_in   = 1'b0;
               state_in      = lctai_pkg::S_DONE;
            end else begin
               // fw + a*(g - fw)/2^16 equals the weighted sum of both terms
               mcand_in = g_minus_fw;
               mq_in    = {{(MQ_W-A_W){1'b0}}, alpha_eff};
               acc_in   = '0;
               step_in  = '0;
               state_in = lctai_pkg::S_IIR;
            end
         end
         lctai_pkg::S_IIR_END: begin
            fw_in         = lctai_pkg::sat32(iir_sum);
            res_weight_in = lctai_pkg::sat32(iir_sum);
            res_tare_in   = 1'b0;
            state_in      = lctai_pkg::S_DONE;
         end
         lctai_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_weight_in = res_weight_ff;
               rsp_tare_in   = res_tare_ff;
               state_in      = lctai_pkg::S_IDLE;
            end
         end
      endcase
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.weight_g_q8 = rsp_weight_ff;
   assign rsp.tare_done   = rsp_tare_ff;

   `LCTAI_ASSERT_SAME(a_cnt_below_need, clock, reset, 1'b1,
                      cnt_ff < lctai_pkg::group_need(group_kind_ff))
   `LCTAI_ASSERT_SAME(a_rem_below_div, clock, reset,
                      state_ff == lctai_pkg::S_DIV, rem_ff < need_ff)
   `LCTAI_ASSERT_SAME(a_tare_zero, clock, reset, rsp.valid && rsp.tare_done,
                      rsp.weight_g_q8 == '0)
   `LCTAI_ASSERT_NEXT(a_group_close, clock, reset,
                      accept && (acc_cnt == need_req),
                      state_ff == lctai_pkg::S_DIV && cnt_ff == '0)

endmodule
`default_nettype wire
